// ===== sv/utf8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8dec_pkg
// Types and constants for the UTF-8 byte decoder.
// ----------------------------------------------------------------------------
package utf8dec_pkg;

    localparam int CP_W  = 31;
    localparam int REM_W = 3;

    // Lead and continuation byte patterns
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [7:0] LEAD5_MASK = 8'hFC;
    localparam logic [7:0] LEAD5_TAG  = 8'hF8;
    localparam logic [7:0] LEAD6_MASK = 8'hFE;
    localparam logic [7:0] LEAD6_TAG  = 8'hFC;
    localparam logic [7:0] PAY2_MASK  = 8'h1F;
    localparam logic [7:0] PAY3_MASK  = 8'h0F;
    localparam logic [7:0] PAY4_MASK  = 8'h07;
    localparam logic [7:0] PAY5_MASK  = 8'h03;
    localparam logic [7:0] PAY6_MASK  = 8'h01;
    localparam logic [7:0] CONT_PAY   = 8'h3F;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            decode_error;
    } result_t;

endpackage

// ===== sv/utf8_byte_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_decoder
// Decodes a stream of legacy UTF-8 bytes (one to six byte sequences) into
// code points, with one error result on a malformed byte.
// ----------------------------------------------------------------------------
// Results are registered: m_tvalid and m_tdata come from the output register.
// Throughput: one byte per cycle while s_tready is high.
// Output side has a two-entry stage (result register plus skid), so s_tready
// drops only when both entries hold results that have not been taken.
// Reset (rst_n low, asynchronous): no sequence pending, not halted, no
// results held.
module utf8_byte_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] string_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] code_point, [31] zero
    output logic [0:0]  m_tuser    // [0] decode_error
);
    import utf8dec_pkg::*;

    logic [REM_W-1:0] rem_reg,  rem_next;
    logic [CP_W-1:0]  part_reg, part_next;
    logic             halted_reg, halted_next;

    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;

    logic             accept, push, pop;
    logic [7:0]       b;
    logic [REM_W-1:0] eff_rem, dec_rem;
    logic [CP_W-1:0]  eff_part, shifted;
    logic             eff_halt;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign b        = s_tdata;

    // String start clears everything before the byte is handled
    assign eff_rem  = s_tuser[0] ? '0 : rem_reg;
    assign eff_part = s_tuser[0] ? '0 : part_reg;
    assign eff_halt = s_tuser[0] ? 1'b0 : halted_reg;
    assign shifted  = {eff_part[CP_W-7:0], b[5:0]};
    assign dec_rem  = eff_rem - REM_W'(1);

    always_comb
    begin
        rem_next    = eff_rem;
        part_next   = eff_part;
        halted_next = eff_halt;
        push        = 1'b0;
        res         = '0;
        if (eff_halt)
        begin
            push = 1'b0;
        end
        else if (eff_rem != '0)
        begin
            if ((b & CONT_MASK) != CONT_TAG)
            begin
                halted_next      = 1'b1;
                rem_next         = '0;
                part_next        = '0;
                push             = 1'b1;
                res.decode_error = 1'b1;
            end
            else
            begin
                rem_next = dec_rem;
                if (dec_rem == '0)
                begin
                    part_next      = '0;
                    push           = 1'b1;
                    res.code_point = shifted;
                end
                else
                begin
                    part_next = shifted;
                end
            end
        end
        else
        begin
            priority if (b == 8'h00)
            begin
                halted_next = 1'b1;
            end
            else if (!b[7])
            begin
                push           = 1'b1;
                res.code_point = CP_W'(b);
            end
            else if ((b & CONT_MASK) == CONT_TAG)
            begin
                halted_next      = 1'b1;
                push             = 1'b1;
                res.decode_error = 1'b1;
            end
            else if ((b & LEAD2_MASK) == LEAD2_TAG)
            begin
                rem_next  = REM_W'(1);
                part_next = CP_W'(b & PAY2_MASK);
            end
            else if ((b & LEAD3_MASK) == LEAD3_TAG)
            begin
                rem_next  = REM_W'(2);
                part_next = CP_W'(b & PAY3_MASK);
            end
            else if ((b & LEAD4_MASK) == LEAD4_TAG)
            begin
                rem_next  = REM_W'(3);
                part_next = CP_W'(b & PAY4_MASK);
            end
            else if ((b & LEAD5_MASK) == LEAD5_TAG)
            begin
                rem_next  = REM_W'(4);
                part_next = CP_W'(b & PAY5_MASK);
            end
            else if ((b & LEAD6_MASK) == LEAD6_TAG)
            begin
                rem_next  = REM_W'(5);
                part_next = CP_W'(b & PAY6_MASK);
            end
            else
            begin
                // 0xFE / 0xFF lead
                halted_next      = 1'b1;
                push             = 1'b1;
                res.decode_error = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            part_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            rem_reg    <= rem_next;
            part_reg   <= part_next;
            halted_reg <= halted_next;
        end
    end

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {1'b0, out_reg.code_point};
    assign m_tuser[0] = out_reg.decode_error;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without result register");

    a_error_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0))
        else $error("error result carries a non-zero code point");

    a_halt_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (rem_reg == '0))
        else $error("halted with a sequence pending");

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && halted_reg && !s_tuser[0]) |-> !push)
        else $error("result produced while halted");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg && !s_tready)
        else $error("skid entry lost while output stalled");

endmodule

// ===== bench/tb_utf8_byte_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_byte_decoder
// Streams legacy UTF-8 bytes into the decoder and scores each code point or
// error transaction against a cycle-free model of the decode state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_utf8_byte_decoder;

    import utf8dec_pkg::*;

    // Tracks the decode state and queues the expected results.
    class cp_scoreboard;
        logic [REM_W-1:0] cont_left;
        logic [CP_W-1:0]  accum;
        bit               halted;
        result_t          pending_cps[$];
        int               mismatches;

        function new();
            cont_left  = '0;
            accum      = '0;
            halted     = 1'b0;
            mismatches = 0;
        endfunction

        function void queue_result(result_t r);
            pending_cps = {pending_cps, r};
        endfunction

        function void fail_string();
            result_t r;
            r              = '0;
            r.decode_error = 1'b1;
            halted         = 1'b1;
            cont_left      = '0;
            accum          = '0;
            queue_result(r);
        endfunction

        function void accept_byte(logic [7:0] b, logic start);
            result_t     r;
            logic [7:0]  pay;
            int unsigned len;
            r = '0;
            if (start)
            begin
                cont_left = '0;
                accum     = '0;
                halted    = 1'b0;
            end
            if (halted)
                return;
            if (cont_left != 0)
            begin
                if ((b & CONT_MASK) != CONT_TAG)
                begin
                    fail_string();
                    return;
                end
                accum     = (accum << 6) | CP_W'(b & CONT_PAY);
                cont_left = cont_left - REM_W'(1);
                if (cont_left == 0)
                begin
                    r.code_point = accum;
                    accum        = '0;
                    queue_result(r);
                end
                return;
            end
            // zero lead ends the string without a result
            if (b == 8'h00)
            begin
                halted = 1'b1;
                return;
            end
            if (!b[7])
            begin
                r.code_point = CP_W'(b);
                queue_result(r);
                return;
            end
            if ((b & CONT_MASK) == CONT_TAG)
            begin
                fail_string();
                return;
            end
            if ((b & LEAD2_MASK) == LEAD2_TAG)
            begin
                len = 2;
                pay = b & PAY2_MASK;
            end
            else if ((b & LEAD3_MASK) == LEAD3_TAG)
            begin
                len = 3;
                pay = b & PAY3_MASK;
            end
            else if ((b & LEAD4_MASK) == LEAD4_TAG)
            begin
                len = 4;
                pay = b & PAY4_MASK;
            end
            else if ((b & LEAD5_MASK) == LEAD5_TAG)
            begin
                len = 5;
                pay = b & PAY5_MASK;
            end
            else if ((b & LEAD6_MASK) == LEAD6_TAG)
            begin
                len = 6;
                pay = b & PAY6_MASK;
            end
            else
            begin
                fail_string();
                return;
            end
            cont_left = REM_W'(len - 1);
            accum     = CP_W'(pay);
        endfunction

        function void match_code_point(logic [31:0] tdata, logic err);
            result_t want;
            if (pending_cps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: cp=%h err=%b", tdata, err);
                return;
            end
            want = pending_cps.pop_front();
            if (tdata[CP_W-1:0] !== want.code_point || tdata[31] !== 1'b0 ||
                err !== want.decode_error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected cp=%h err=%b, got cp=%h pad=%b err=%b",
                             want.code_point, want.decode_error,
                             tdata[CP_W-1:0], tdata[31], err);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [0:0]  s_tuser;   // [0] string_start
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [30:0] code_point, [31] zero
    logic [0:0]  m_tuser;   // [0] decode_error

    cp_scoreboard sb = new();
    int           cyc = 0;
    int           items_sent = 0;

    utf8_byte_decoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cyc <= cyc + 1;

    function automatic bit no_idle_window();
        return cyc >= 1500 && cyc < 2100;
    endfunction

    // Handshakes are sampled mid-cycle, when everything driven at the edge
    // has settled; the transaction itself completes at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid && m_tready)
            sb.match_code_point(m_tdata, m_tuser[0]);
    end

    task automatic send_byte(input logic [7:0] b, input logic st);
        items_sent++;
        while (!no_idle_window() && $urandom_range(0, 99) < 38)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do
            @(negedge clk);
        while (!s_tready);
        sb.accept_byte(b, st);
        @(posedge clk);
    endtask

    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        unique case (len)
            1:       return {1'b0, r[6:0]};
            2:       return (r & ~LEAD2_MASK) | LEAD2_TAG;
            3:       return (r & ~LEAD3_MASK) | LEAD3_TAG;
            4:       return (r & ~LEAD4_MASK) | LEAD4_TAG;
            5:       return (r & ~LEAD5_MASK) | LEAD5_TAG;
            default: return (r & ~LEAD6_MASK) | LEAD6_TAG;
        endcase
    endfunction

    // A sequence of len bytes; at position cut a random byte replaces the
    // continuation and the sequence stops there.
    task automatic send_seq(input int len, input bit start, input int cut);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                b = lead_byte(len);
            else if (i == cut)
                b = 8'($urandom);
            else
                b = CONT_TAG | (8'($urandom) & CONT_PAY);
            send_byte(b, start && i == 0);
            if (i == cut)
                break;
        end
    endtask

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            // long back-pressure so the output stage fills and stalls input
            if (cyc == 500)
                hold_left = 90;
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= no_idle_window() || ($urandom_range(0, 99) >= 38);
        end
    end

    initial
    begin : stimulus
        logic [8:0] directed_seq [$];
        int         waited;
        int         pick;
        int         len;
        bit         start;
        logic [7:0] noise;

        // {string_start, data_byte}
        directed_seq = '{9'h141, 9'h07F,                   // ASCII
                         9'h0C2, 9'h0A9,                   // two bytes
                         9'h0E2, 9'h082, 9'h0AC,           // three bytes
                         9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,   // four bytes
                         9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF,   // six bytes, all ones
                         9'h0BF, 9'h0BF,
                         9'h080, 9'h041,                   // stray continuation, halted
                         9'h1FE, 9'h1FF,                   // invalid leads
                         9'h1C3, 9'h041,                   // non-continuation in sequence
                         9'h100, 9'h041,                   // zero lead, then ignored
                         9'h1F8, 9'h088, 9'h141};          // pending sequence dropped

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_seq[i])
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);

        while (items_sent < 1400)
        begin
            pick  = $urandom_range(0, 99);
            start = ($urandom_range(0, 99) < 10) ||
                    (sb.halted && $urandom_range(0, 99) < 85);
            if (pick < 65)
                send_seq($urandom_range(1, 6), start, 6);
            else if (pick < 80)
            begin
                len = $urandom_range(2, 6);
                send_seq(len, start, $urandom_range(1, len - 1));
            end
            else
            begin
                noise = ($urandom_range(0, 99) < 5) ? 8'h00 : 8'($urandom);
                send_byte(noise, 1'($urandom_range(0, 1)));
            end
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (sb.pending_cps.size() != 0 && waited < 50000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.pending_cps.size() != 0)
        begin
            $display("%0d expected transactions never arrived", sb.pending_cps.size());
            sb.mismatches += sb.pending_cps.size();
        end
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/utf8dec_pkg.sv
sv/utf8_byte_decoder.sv
bench/tb_utf8_byte_decoder.sv
